FILE: design/ssad_pkg.sv
// ----------------------------------------------------------------------------
// ssad_pkg: shared types and constants of the autorange display
// Reciprocal constants for the decimal split, register map, glyph table.
// ----------------------------------------------------------------------------
package ssad_pkg;

	// field widths
	localparam int TEMP_W  = 17;
	localparam int CNT_W   = 16;
	localparam int SEG_W   = 7;
	localparam int POS_N   = 4;
	localparam int DIGIT_N = 5;

	// largest reading shown (999.99)
	localparam logic [TEMP_W-1:0] TEMP_MAX = 17'd99999;

	// reciprocal multipliers: x / d = (x * M) >> S, exact for x <= TEMP_MAX
	localparam int RECIP_W = 19;
	localparam int PROD_W  = TEMP_W + RECIP_W;
	localparam logic [RECIP_W-1:0] RECIP_DIV10    = 19'd419431;
	localparam logic [RECIP_W-1:0] RECIP_DIV100   = 19'd167773;
	localparam logic [RECIP_W-1:0] RECIP_DIV1000  = 19'd134218;
	localparam logic [RECIP_W-1:0] RECIP_DIV10000 = 19'd107375;
	localparam int SHIFT_DIV10    = 22;
	localparam int SHIFT_DIV100   = 24;
	localparam int SHIFT_DIV1000  = 27;
	localparam int SHIFT_DIV10000 = 30;

	// quotient widths (TEMP_MAX / 10^k)
	localparam int Q1_W = 14;
	localparam int Q2_W = 10;
	localparam int Q3_W = 7;
	localparam int Q4_W = 4;

	// decimal point scale codes
	localparam logic [1:0] SCALE_X_XX = 2'd0;
	localparam logic [1:0] SCALE_XX_X = 2'd1;
	localparam logic [1:0] SCALE_XXX  = 2'd2;

	// digit positions
	localparam logic [1:0] POS_FIRST  = 2'd0;
	localparam logic [1:0] POS_SECOND = 2'd1;
	localparam logic [1:0] POS_THIRD  = 2'd2;
	localparam logic [1:0] POS_DEGREE = 2'd3;

	// configuration map
	localparam int CFG_ADDR_W = 4;
	localparam int CFG_DATA_W = 32;
	localparam logic [1:0] REG_HOLD_PERIOD     = 2'd0;
	localparam logic [1:0] REG_BLINK_THRESHOLD = 2'd1;
	localparam logic [1:0] REG_BLINK_PERIOD    = 2'd2;

	localparam logic [CNT_W-1:0] HOLD_PERIOD_RST     = 16'd10;
	localparam logic [CNT_W-1:0] BLINK_THRESHOLD_RST = 16'd50;
	localparam logic [CNT_W-1:0] BLINK_PERIOD_RST    = 16'd100;

	// degree sign: segments a, b, f, g
	localparam logic [SEG_W-1:0] DEGREE_GLYPH = 7'h63;

	typedef logic [DIGIT_N-1:0][3:0] ssad_digits_t;

	typedef struct packed {
		logic [CNT_W-1:0] hold_period;
		logic [CNT_W-1:0] blink_threshold;
		logic [CNT_W-1:0] blink_period;
	} ssad_cfg_t;

	// one reading after the reciprocal multiply stage
	typedef struct packed {
		logic [TEMP_W-1:0] q0;
		logic [Q1_W-1:0]   q1;
		logic [Q2_W-1:0]   q2;
		logic [Q3_W-1:0]   q3;
		logic [Q4_W-1:0]   q4;
		logic [1:0]        scale;
		logic              alert_request;
		logic              force_load;
	} ssad_quot_t;

	// seven-segment pattern of a decimal digit, a..g in bits 0..6
	function automatic logic [SEG_W-1:0] glyph(input logic [3:0] digit);
		logic [SEG_W-1:0] seg;
		unique case (digit)
			4'd0: seg = 7'h3F;
			4'd1: seg = 7'h06;
			4'd2: seg = 7'h5B;
			4'd3: seg = 7'h4F;
			4'd4: seg = 7'h66;
			4'd5: seg = 7'h6D;
			4'd6: seg = 7'h7D;
			4'd7: seg = 7'h07;
			4'd8: seg = 7'h7F;
			4'd9: seg = 7'h6F;
			default: seg = 7'h3F;
		endcase
		return seg;
	endfunction

endpackage

FILE: design/ssad_sample_if.sv
// ----------------------------------------------------------------------------
// ssad_sample_if: reading channel
// Valid/ready channel carrying one refresh-tick request.
// ----------------------------------------------------------------------------
interface ssad_sample_if;
	logic                        valid;
	logic                        ready;
	logic [ssad_pkg::TEMP_W-1:0] temperature_hundredths;
	logic                        alert_request;
	logic                        force_load;

	modport source (
		output valid, temperature_hundredths, alert_request, force_load,
		input  ready
	);
	modport sink (
		input  valid, temperature_hundredths, alert_request, force_load,
		output ready
	);
endinterface

FILE: design/ssad_result_if.sv
// ----------------------------------------------------------------------------
// ssad_result_if: display drive channel
// Valid/ready channel carrying one multiplexed display drive word.
// ----------------------------------------------------------------------------
interface ssad_result_if;
	logic                       valid;
	logic                       ready;
	logic [ssad_pkg::SEG_W-1:0] segments;
	logic                       decimal_point;
	logic [ssad_pkg::POS_N-1:0] digit_enable;

	modport source (
		output valid, segments, decimal_point, digit_enable,
		input  ready
	);
	modport sink (
		input  valid, segments, decimal_point, digit_enable,
		output ready
	);
endinterface

FILE: design/seven_segment_autorange_display.sv
// A request accepted at the input passes the input register and the reciprocal multiply
// register, then digit split, counter update and output register, before its drive word
// is on the output. Throughput: one request per cycle while the result sink is ready.
// Reset (arst_n low) empties the pipeline, clears held value, counters, blank flag and
// position, and loads hold_period 10, blink_threshold 50, blink_period 100.
// ----------------------------------------------------------------------------
// seven_segment_autorange_display: autorange multiplexed temperature display
// Drives one of three digits or the degree sign per request, with held value,
// autoranged decimal point and alert blinking.
// ----------------------------------------------------------------------------
module seven_segment_autorange_display (
	input  logic                            clk,
	input  logic                            arst_n,
	ssad_sample_if.sink                     sample,
	ssad_result_if.source                   result,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [ssad_pkg::CFG_ADDR_W-1:0] paddr,
	input  logic [ssad_pkg::CFG_DATA_W-1:0] pwdata,
	output logic [ssad_pkg::CFG_DATA_W-1:0] prdata,
	output logic                            pready
);

	ssad_pkg::ssad_cfg_t  cfg;
	logic                 quot_valid;
	ssad_pkg::ssad_quot_t quot;
	logic                 disp_ready;

	ssad_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	ssad_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.sample     (sample),
		.down_ready (disp_ready),
		.quot_valid (quot_valid),
		.quot       (quot)
	);

	ssad_display u_display (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg),
		.quot_valid (quot_valid),
		.quot       (quot),
		.up_ready   (disp_ready),
		.result     (result)
	);

endmodule

FILE: design/ssad_regs.sv
// ----------------------------------------------------------------------------
// ssad_regs: configuration registers
// APB-style write/read of hold period, blink threshold and blink period.
// ----------------------------------------------------------------------------
module ssad_regs (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [ssad_pkg::CFG_ADDR_W-1:0] paddr,
	input  logic [ssad_pkg::CFG_DATA_W-1:0] pwdata,
	output logic [ssad_pkg::CFG_DATA_W-1:0] prdata,
	output logic                            pready,
	output ssad_pkg::ssad_cfg_t             cfg
);

	ssad_pkg::ssad_cfg_t cfg_q;
	logic [1:0]          reg_idx;
	logic                wr_en;

	assign reg_idx = paddr[3:2];
	assign wr_en   = psel && penable && pwrite;
	assign pready  = 1'b1;
	assign cfg     = cfg_q;

	// register writes; an index past the map is dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.hold_period     <= ssad_pkg::HOLD_PERIOD_RST;
			cfg_q.blink_threshold <= ssad_pkg::BLINK_THRESHOLD_RST;
			cfg_q.blink_period    <= ssad_pkg::BLINK_PERIOD_RST;
		end else if (wr_en) begin
			unique case (reg_idx)
				ssad_pkg::REG_HOLD_PERIOD:     cfg_q.hold_period     <= pwdata[15:0];
				ssad_pkg::REG_BLINK_THRESHOLD: cfg_q.blink_threshold <= pwdata[15:0];
				ssad_pkg::REG_BLINK_PERIOD:    cfg_q.blink_period    <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	// read back
	always_comb begin
		unique case (reg_idx)
			ssad_pkg::REG_HOLD_PERIOD:     prdata = {16'b0, cfg_q.hold_period};
			ssad_pkg::REG_BLINK_THRESHOLD: prdata = {16'b0, cfg_q.blink_threshold};
			ssad_pkg::REG_BLINK_PERIOD:    prdata = {16'b0, cfg_q.blink_period};
			default:                       prdata = '0;
		endcase
	end

endmodule

FILE: design/ssad_front.sv
// ----------------------------------------------------------------------------
// ssad_front: input register and decimal quotient stage
// Clamps the reading, picks the scale and forms t/10..t/10000 by reciprocal
// multiplies, registered for the display stage.
// ----------------------------------------------------------------------------
module ssad_front (
	input  logic                   clk,
	input  logic                   arst_n,
	ssad_sample_if.sink            sample,
	input  logic                   down_ready,
	output logic                   quot_valid,
	output ssad_pkg::ssad_quot_t   quot
);

	logic                        valid_s1;
	logic [ssad_pkg::TEMP_W-1:0] temp_s1;
	logic                        alert_s1;
	logic                        force_s1;
	logic                        valid_s2;
	ssad_pkg::ssad_quot_t        quot_s2;
	logic                        ready_s1;
	logic                        ready_s2;
	logic [ssad_pkg::TEMP_W-1:0] temp_clamp;
	logic [ssad_pkg::PROD_W-1:0] prod10;
	logic [ssad_pkg::PROD_W-1:0] prod100;
	logic [ssad_pkg::PROD_W-1:0] prod1000;
	logic [ssad_pkg::PROD_W-1:0] prod10000;
	ssad_pkg::ssad_quot_t        quot_nxt;

	// each stage moves when it is empty or the next one takes
	assign ready_s2     = !valid_s2 || down_ready;
	assign ready_s1     = !valid_s1 || ready_s2;
	assign sample.ready = ready_s1;
	assign quot_valid   = valid_s2;
	assign quot         = quot_s2;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (ready_s1) begin
			valid_s1 <= sample.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s1 && sample.valid) begin
			temp_s1  <= sample.temperature_hundredths;
			alert_s1 <= sample.alert_request;
			force_s1 <= sample.force_load;
		end
	end

	// clamp, scale and quotients
	always_comb begin
		temp_clamp = (temp_s1 > ssad_pkg::TEMP_MAX) ? ssad_pkg::TEMP_MAX : temp_s1;
		prod10     = ssad_pkg::PROD_W'(temp_clamp) * ssad_pkg::PROD_W'(ssad_pkg::RECIP_DIV10);
		prod100    = ssad_pkg::PROD_W'(temp_clamp) * ssad_pkg::PROD_W'(ssad_pkg::RECIP_DIV100);
		prod1000   = ssad_pkg::PROD_W'(temp_clamp) * ssad_pkg::PROD_W'(ssad_pkg::RECIP_DIV1000);
		prod10000  = ssad_pkg::PROD_W'(temp_clamp)
			* ssad_pkg::PROD_W'(ssad_pkg::RECIP_DIV10000);

		quot_nxt.q0 = temp_clamp;
		quot_nxt.q1 = prod10[ssad_pkg::SHIFT_DIV10 +: ssad_pkg::Q1_W];
		quot_nxt.q2 = prod100[ssad_pkg::SHIFT_DIV100 +: ssad_pkg::Q2_W];
		quot_nxt.q3 = prod1000[ssad_pkg::SHIFT_DIV1000 +: ssad_pkg::Q3_W];
		quot_nxt.q4 = prod10000[ssad_pkg::SHIFT_DIV10000 +: ssad_pkg::Q4_W];

		if (temp_clamp >= 17'd10000) begin
			quot_nxt.scale = ssad_pkg::SCALE_XXX;
		end else if (temp_clamp >= 17'd1000) begin
			quot_nxt.scale = ssad_pkg::SCALE_XX_X;
		end else begin
			quot_nxt.scale = ssad_pkg::SCALE_X_XX;
		end
		quot_nxt.alert_request = alert_s1;
		quot_nxt.force_load    = force_s1;
	end

	// quotient register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (ready_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s2 && valid_s1) begin
			quot_s2 <= quot_nxt;
		end
	end

endmodule

FILE: design/ssad_display.sv
// ----------------------------------------------------------------------------
// ssad_display: hold, blink and multiplex stage
// Splits the reading into digits, updates hold and blink counters, picks the
// active position and registers the drive word.
// ----------------------------------------------------------------------------
module ssad_display (
	input  logic                 clk,
	input  logic                 arst_n,
	input  ssad_pkg::ssad_cfg_t  cfg,
	input  logic                 quot_valid,
	input  ssad_pkg::ssad_quot_t quot,
	output logic                 up_ready,
	ssad_result_if.source        result
);

	// state
	ssad_pkg::ssad_digits_t       held_q;
	logic [ssad_pkg::CNT_W-1:0]   hold_cnt_q;
	logic [ssad_pkg::CNT_W-1:0]   blink_cnt_q;
	logic                         blank_q;
	logic [1:0]                   pos_q;
	logic                         out_valid_q;
	logic [ssad_pkg::SEG_W-1:0]   segments_q;
	logic                         dp_q;
	logic [ssad_pkg::POS_N-1:0]   enable_q;

	logic                         fire;
	ssad_pkg::ssad_digits_t       new_digits;
	ssad_pkg::ssad_digits_t       held_nxt;
	logic [ssad_pkg::CNT_W-1:0]   hold_base;
	logic [ssad_pkg::CNT_W:0]     hold_inc;
	logic [ssad_pkg::CNT_W-1:0]   hold_nxt;
	logic [ssad_pkg::CNT_W:0]     blink_inc;
	logic [ssad_pkg::CNT_W-1:0]   blink_nxt;
	logic                         blank_nxt;
	logic [3:0]                   digit;
	logic [ssad_pkg::SEG_W-1:0]   seg_nxt;
	logic                         dp_nxt;
	logic [ssad_pkg::POS_N-1:0]   en_nxt;

	assign up_ready = !out_valid_q || result.ready;
	assign fire     = quot_valid && up_ready;

	// decimal digits: d_k = q_k - 10 * q_(k+1)
	always_comb begin
		new_digits[0] = 4'(quot.q0 - 17'(quot.q1) * 17'd10);
		new_digits[1] = 4'(quot.q1 - 14'(quot.q2) * 14'd10);
		new_digits[2] = 4'(quot.q2 - 10'(quot.q3) * 10'd10);
		new_digits[3] = 4'(quot.q3 - 7'(quot.q4) * 7'd10);
		new_digits[4] = quot.q4;
	end

	// hold period and blink counters
	always_comb begin
		hold_base = quot.force_load ? '0 : hold_cnt_q;
		held_nxt  = (hold_base == '0) ? new_digits : held_q;
		hold_inc  = {1'b0, hold_base} + 17'd1;
		hold_nxt  = (hold_inc >= {1'b0, cfg.hold_period}) ? '0 : hold_inc[ssad_pkg::CNT_W-1:0];

		blink_inc = {1'b0, blink_cnt_q} + 17'd1;
		blink_nxt = (blink_inc >= {1'b0, cfg.blink_period})
			? '0 : blink_inc[ssad_pkg::CNT_W-1:0];

		if (!quot.alert_request) begin
			blank_nxt = 1'b0;
		end else if (blank_q) begin
			blank_nxt = !(blink_cnt_q > cfg.blink_threshold);
		end else begin
			blank_nxt = blink_cnt_q < cfg.blink_threshold;
		end
	end

	// digit selection; an over-range first digit shows as zero
	always_comb begin
		digit = '0;
		unique case (quot.scale)
			ssad_pkg::SCALE_X_XX: begin
				unique case (pos_q)
					ssad_pkg::POS_FIRST:
						digit = (held_nxt[4] != '0 || held_nxt[3] != '0) ? 4'd0 : held_nxt[2];
					ssad_pkg::POS_SECOND: digit = held_nxt[1];
					default:              digit = held_nxt[0];
				endcase
			end
			ssad_pkg::SCALE_XX_X: begin
				unique case (pos_q)
					ssad_pkg::POS_FIRST:  digit = (held_nxt[4] != '0) ? 4'd0 : held_nxt[3];
					ssad_pkg::POS_SECOND: digit = held_nxt[2];
					default:              digit = held_nxt[1];
				endcase
			end
			default: begin
				unique case (pos_q)
					ssad_pkg::POS_FIRST:  digit = held_nxt[4];
					ssad_pkg::POS_SECOND: digit = held_nxt[3];
					default:              digit = held_nxt[2];
				endcase
			end
		endcase

		if (pos_q == ssad_pkg::POS_DEGREE) begin
			seg_nxt = ssad_pkg::DEGREE_GLYPH;
			dp_nxt  = 1'b0;
		end else begin
			seg_nxt = ssad_pkg::glyph(digit);
			dp_nxt  = (quot.scale == pos_q);
		end
		en_nxt = ssad_pkg::POS_N'(1) << pos_q;

		if (blank_nxt) begin
			seg_nxt = '0;
			dp_nxt  = 1'b0;
			en_nxt  = '0;
		end
	end

	// state and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q      <= '0;
			hold_cnt_q  <= '0;
			blink_cnt_q <= '0;
			blank_q     <= 1'b0;
			pos_q       <= ssad_pkg::POS_FIRST;
			out_valid_q <= 1'b0;
		end else begin
			if (up_ready) begin
				out_valid_q <= quot_valid;
			end
			if (fire) begin
				held_q      <= held_nxt;
				hold_cnt_q  <= hold_nxt;
				blink_cnt_q <= blink_nxt;
				blank_q     <= blank_nxt;
				pos_q       <= pos_q + 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			segments_q <= seg_nxt;
			dp_q       <= dp_nxt;
			enable_q   <= en_nxt;
		end
	end

	assign result.valid         = out_valid_q;
	assign result.segments      = segments_q;
	assign result.decimal_point = dp_q;
	assign result.digit_enable  = enable_q;

`ifndef SYNTHESIS
	// at most one position driven
	a_enable_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> $onehot0(enable_q))
		else $error("digit_enable not one-hot");

	// a blanked word carries no lit segment or point
	a_blank_dark: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && enable_q == '0) |-> (segments_q == '0 && !dp_q))
		else $error("blanked word has lit segments");

	// position steps once per request taken
	a_pos_step: assert property (@(posedge clk) disable iff (!arst_n)
		fire |=> pos_q == $past(pos_q) + 2'd1)
		else $error("position did not advance");

	// held digits stay decimal
	a_held_decimal: assert property (@(posedge clk) disable iff (!arst_n)
		held_q[0] < 4'd10 && held_q[1] < 4'd10 && held_q[2] < 4'd10
		&& held_q[3] < 4'd10 && held_q[4] < 4'd10)
		else $error("held digit above nine");
`endif

endmodule

FILE: test/seven_segment_autorange_display_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// seven_segment_autorange_display_tb: refresh-tick scoreboard bench
// Drives readings with bursty valid and a stalling display sink, predicts each
// drive word (held value, autorange point, blink blanking) and checks it.
// Register settings change between phases while the block is idle.
// ----------------------------------------------------------------------------
module seven_segment_autorange_display_tb;

	localparam logic [1:0] REG_UNMAPPED = 2'd3;
	localparam int TICKS_PER_PHASE = 262;
	localparam int PHASE_N = 7;
	localparam int LONG_STALL_CYCLES = 80;

	// digit patterns, a..g in bits 0..6
	localparam logic [ssad_pkg::SEG_W-1:0] DIGIT_GLYPH [10] = '{
		7'h3F, 7'h06, 7'h5B, 7'h4F, 7'h66, 7'h6D, 7'h7D, 7'h07, 7'h7F, 7'h6F
	};
	localparam int EDGE_READINGS [10] = '{
		0, 999, 1000, 9999, 10000, 99999, 100000, 131071, 65536, 1
	};

	typedef struct packed {
		logic [ssad_pkg::TEMP_W-1:0] temp;
		logic                        alert;
		logic                        force_load;
	} reading_t;

	typedef struct packed {
		logic [ssad_pkg::SEG_W-1:0] segments;
		logic                       decimal_point;
		logic [ssad_pkg::POS_N-1:0] digit_enable;
	} drive_word_t;

	logic clk;
	logic arst_n;
	logic psel, penable, pwrite, pready;
	logic [ssad_pkg::CFG_ADDR_W-1:0] paddr;
	logic [ssad_pkg::CFG_DATA_W-1:0] pwdata, prdata;

	ssad_sample_if sample_bus ();
	ssad_result_if result_bus ();

	seven_segment_autorange_display u_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.sample  (sample_bus),
		.result  (result_bus),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	// predictor copy of registers and state
	logic [ssad_pkg::CNT_W-1:0]  cfg_hold_period;
	logic [ssad_pkg::CNT_W-1:0]  cfg_blink_threshold;
	logic [ssad_pkg::CNT_W-1:0]  cfg_blink_period;
	logic [ssad_pkg::TEMP_W-1:0] shown_value;
	logic [ssad_pkg::CNT_W-1:0]  hold_cnt;
	logic [ssad_pkg::CNT_W-1:0]  blink_cnt;
	logic                        blanked;
	logic [1:0]                  active_pos;

	reading_t    pending_readings [$];
	drive_word_t expected_drive [$];
	int          ticks_issued;
	int          ticks_accepted;
	int          fail_count;
	logic        sample_fire;

	// sender burst shaping
	int burst_left;
	int gap_left;

	// sink stall shaping
	int ready_run_left;
	int long_stall_req;
	int long_stall_done;
	int long_stall_left;

	always #6 clk = ~clk;

	// counter step: wraps once count+1 reaches the period
	function automatic logic [ssad_pkg::CNT_W-1:0] count_step(
			input logic [ssad_pkg::CNT_W-1:0] cnt,
			input logic [ssad_pkg::CNT_W-1:0] period);
		logic [ssad_pkg::CNT_W:0] nxt;
		nxt = {1'b0, cnt} + 1'b1;
		return (nxt >= {1'b0, period}) ? '0 : nxt[ssad_pkg::CNT_W-1:0];
	endfunction

	// one refresh tick of the display
	function automatic drive_word_t predict_display(input reading_t rd);
		drive_word_t w;
		logic [ssad_pkg::TEMP_W-1:0] t;
		logic [1:0] scale;
		int unit;
		int digit;
		t = (rd.temp > ssad_pkg::TEMP_MAX) ? ssad_pkg::TEMP_MAX : rd.temp;
		scale = (t >= 10000) ? ssad_pkg::SCALE_XXX
			: (t >= 1000) ? ssad_pkg::SCALE_XX_X : ssad_pkg::SCALE_X_XX;

		if (rd.force_load) hold_cnt = '0;
		if (hold_cnt == '0) shown_value = t;
		hold_cnt = count_step(hold_cnt, cfg_hold_period);

		if (!rd.alert) blanked = 1'b0;
		else if (blanked) begin
			if (blink_cnt > cfg_blink_threshold) blanked = 1'b0;
		end else if (blink_cnt < cfg_blink_threshold) begin
			blanked = 1'b1;
		end
		blink_cnt = count_step(blink_cnt, cfg_blink_period);

		unit = (scale == ssad_pkg::SCALE_X_XX) ? 10
			: (scale == ssad_pkg::SCALE_XX_X) ? 100 : 1000;
		if (active_pos == ssad_pkg::POS_DEGREE) begin
			w.segments = ssad_pkg::DEGREE_GLYPH;
			w.decimal_point = 1'b0;
		end else begin
			case (active_pos)
				ssad_pkg::POS_FIRST: digit = int'(shown_value) / (unit * 10);
				ssad_pkg::POS_SECOND: digit = (int'(shown_value) / unit) % 10;
				default: digit = (int'(shown_value) / (unit / 10)) % 10;
			endcase
			if (digit > 9) digit = 0;
			w.segments = DIGIT_GLYPH[digit];
			w.decimal_point = (scale == active_pos);
		end
		w.digit_enable = 4'b0001 << active_pos;
		if (blanked) w = '0;
		active_pos = active_pos + 2'd1;
		return w;
	endfunction

	// spread readings over all three scales, the clamp and the edges
	function automatic reading_t random_reading(input logic alert);
		reading_t r;
		case ($urandom_range(0, 9))
			0, 1: r.temp = ssad_pkg::TEMP_W'($urandom_range(0, 999));
			2, 3: r.temp = ssad_pkg::TEMP_W'($urandom_range(1000, 9999));
			4, 5, 6: r.temp = ssad_pkg::TEMP_W'($urandom_range(10000, 99999));
			7: r.temp = ssad_pkg::TEMP_W'($urandom_range(99999, 131071));
			8: r.temp = ssad_pkg::TEMP_W'(EDGE_READINGS[$urandom_range(0, 9)]);
			default: r.temp = ssad_pkg::TEMP_W'($urandom_range(0, 131071));
		endcase
		r.alert = alert;
		r.force_load = ($urandom_range(0, 15) == 0);
		return r;
	endfunction

	task automatic queue_reading(input logic [ssad_pkg::TEMP_W-1:0] t, input logic alert,
			input logic force_ld);
		reading_t r;
		r.temp = t;
		r.alert = alert;
		r.force_load = force_ld;
		pending_readings.push_back(r);
		ticks_issued++;
	endtask

	// block until every request went in and every drive word came out
	task automatic wait_drained();
		do @(negedge clk);
		while (ticks_accepted != ticks_issued || expected_drive.size() != 0);
	endtask

	// APB write: setup cycle, then access cycle
	task automatic write_reg(input logic [1:0] idx,
			input logic [ssad_pkg::CNT_W-1:0] value);
		@(negedge clk);
		psel = 1'b1;
		penable = 1'b0;
		pwrite = 1'b1;
		paddr = {idx, 2'b00};
		pwdata = {16'($urandom()), value};
		@(negedge clk);
		penable = 1'b1;
		do @(posedge clk); while (!pready);
		case (idx)
			ssad_pkg::REG_HOLD_PERIOD: cfg_hold_period = value;
			ssad_pkg::REG_BLINK_THRESHOLD: cfg_blink_threshold = value;
			ssad_pkg::REG_BLINK_PERIOD: cfg_blink_period = value;
			default: ;
		endcase
		@(negedge clk);
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
	endtask

	// accept requests, predict, and check drive words
	always @(posedge clk) begin : scoreboard
		reading_t rd;
		drive_word_t got;
		drive_word_t want;
		sample_fire = arst_n && sample_bus.valid && sample_bus.ready;
		if (sample_fire) begin
			rd.temp = sample_bus.temperature_hundredths;
			rd.alert = sample_bus.alert_request;
			rd.force_load = sample_bus.force_load;
			expected_drive.push_back(predict_display(rd));
			ticks_accepted++;
		end
		if (arst_n && result_bus.valid && result_bus.ready) begin
			got.segments = result_bus.segments;
			got.decimal_point = result_bus.decimal_point;
			got.digit_enable = result_bus.digit_enable;
			if (expected_drive.size() == 0) begin
				fail_count++;
				$display("%0t: drive word with none expected, got seg %h dp %b en %b",
					$time, got.segments, got.decimal_point, got.digit_enable);
			end else begin
				want = expected_drive.pop_front();
				if (got.segments !== want.segments) begin
					fail_count++;
					$display("%0t: segments expected %h got %h",
						$time, want.segments, got.segments);
				end
				if (got.decimal_point !== want.decimal_point) begin
					fail_count++;
					$display("%0t: decimal_point expected %b got %b",
						$time, want.decimal_point, got.decimal_point);
				end
				if (got.digit_enable !== want.digit_enable) begin
					fail_count++;
					$display("%0t: digit_enable expected %b got %b",
						$time, want.digit_enable, got.digit_enable);
				end
			end
		end
	end

	// sender: bursts of requests with random gaps
	always @(negedge clk) begin : drive_readings
		reading_t nxt;
		if (!arst_n) begin
			sample_bus.valid <= 1'b0;
		end else if (!sample_bus.valid || sample_fire) begin
			if (gap_left > 0) begin
				gap_left--;
				sample_bus.valid <= 1'b0;
			end else if (pending_readings.size() > 0) begin
				nxt = pending_readings.pop_front();
				sample_bus.temperature_hundredths <= nxt.temp;
				sample_bus.alert_request <= nxt.alert;
				sample_bus.force_load <= nxt.force_load;
				sample_bus.valid <= 1'b1;
				if (burst_left > 0) begin
					burst_left--;
				end else begin
					burst_left = $urandom_range(1, 40);
					gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
				end
			end else begin
				sample_bus.valid <= 1'b0;
			end
		end
	end

	// sink: runs of ready and stall, plus long hold-offs on request
	always @(negedge clk) begin : drive_ready
		if (long_stall_left > 0) begin
			long_stall_left--;
			result_bus.ready <= 1'b0;
		end else if (long_stall_req != long_stall_done) begin
			long_stall_done++;
			long_stall_left = LONG_STALL_CYCLES;
			result_bus.ready <= 1'b0;
		end else if (ready_run_left > 0) begin
			ready_run_left--;
		end else begin
			case ($urandom_range(0, 5))
				0, 1: begin
					result_bus.ready <= 1'b0;
					ready_run_left = $urandom_range(0, 6);
				end
				2: begin
					result_bus.ready <= 1'b1;
					ready_run_left = $urandom_range(50, 200);
				end
				default: begin
					result_bus.ready <= 1'b1;
					ready_run_left = $urandom_range(0, 30);
				end
			endcase
		end
	end

	initial begin : watchdog
		#5000000;
		$display("status: fail");
		$finish;
	end

	initial begin : run
		logic alert_now;
		int alert_left;
		clk = 1'b0;
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		sample_bus.valid = 1'b0;
		sample_bus.temperature_hundredths = '0;
		sample_bus.alert_request = 1'b0;
		sample_bus.force_load = 1'b0;
		result_bus.ready = 1'b0;
		sample_fire = 1'b0;
		ticks_issued = 0;
		ticks_accepted = 0;
		fail_count = 0;
		burst_left = 0;
		gap_left = 0;
		ready_run_left = 0;
		long_stall_req = 0;
		long_stall_done = 0;
		long_stall_left = 0;

		// state after reset
		cfg_hold_period = ssad_pkg::HOLD_PERIOD_RST;
		cfg_blink_threshold = ssad_pkg::BLINK_THRESHOLD_RST;
		cfg_blink_period = ssad_pkg::BLINK_PERIOD_RST;
		shown_value = '0;
		hold_cnt = '0;
		blink_cnt = '0;
		blanked = 1'b0;
		active_pos = ssad_pkg::POS_FIRST;

		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: scale edges and clamp, each latched by force
		queue_reading(17'd0, 1'b0, 1'b1);
		queue_reading(17'd999, 1'b0, 1'b1);
		queue_reading(17'd1000, 1'b0, 1'b1);
		queue_reading(17'd9999, 1'b0, 1'b1);
		queue_reading(17'd10000, 1'b0, 1'b1);
		queue_reading(17'd99999, 1'b0, 1'b1);
		queue_reading(17'd100000, 1'b0, 1'b1);
		queue_reading(17'h1FFFF, 1'b0, 1'b1);
		// held 999.99 shown at X.XX scale: first digit above nine
		queue_reading(17'd5, 1'b0, 1'b0);
		queue_reading(17'd42, 1'b0, 1'b0);
		queue_reading(17'd1234, 1'b0, 1'b0);
		queue_reading(17'd54321, 1'b0, 1'b0);
		// hold period still running without force: the held value stays
		queue_reading(17'd12345, 1'b0, 1'b0);
		queue_reading(17'd678, 1'b0, 1'b0);
		// alert while blink count is under the threshold blanks
		queue_reading(17'd31415, 1'b1, 1'b1);
		queue_reading(17'd27182, 1'b1, 1'b0);
		queue_reading(17'd500, 1'b1, 1'b0);
		queue_reading(17'd7777, 1'b1, 1'b0);
		queue_reading(17'd65536, 1'b0, 1'b0);
		queue_reading(17'd88888, 1'b1, 1'b1);
		wait_drained();

		// random phases, each under its own register setting
		alert_now = 1'b0;
		alert_left = 0;
		for (int ph = 0; ph < PHASE_N; ph++) begin
			case (ph)
				0: begin
					write_reg(ssad_pkg::REG_HOLD_PERIOD, 16'd1);
					write_reg(ssad_pkg::REG_BLINK_THRESHOLD, 16'd0);
					write_reg(ssad_pkg::REG_BLINK_PERIOD, 16'd1);
				end
				1: begin
					write_reg(ssad_pkg::REG_HOLD_PERIOD, 16'd65535);
					write_reg(ssad_pkg::REG_BLINK_THRESHOLD, 16'd65535);
					write_reg(ssad_pkg::REG_BLINK_PERIOD, 16'd65535);
				end
				2: begin
					// blink count left above the new period wraps
					write_reg(ssad_pkg::REG_HOLD_PERIOD, 16'd4);
					write_reg(ssad_pkg::REG_BLINK_THRESHOLD, 16'd6);
					write_reg(ssad_pkg::REG_BLINK_PERIOD, 16'd13);
				end
				3: begin
					write_reg(ssad_pkg::REG_HOLD_PERIOD, 16'd17);
					write_reg(ssad_pkg::REG_BLINK_THRESHOLD, 16'd30);
					write_reg(ssad_pkg::REG_BLINK_PERIOD, 16'd25);
				end
				4: begin
					write_reg(ssad_pkg::REG_HOLD_PERIOD, 16'($urandom_range(1, 50)));
					write_reg(ssad_pkg::REG_BLINK_THRESHOLD, 16'($urandom_range(0, 60)));
					write_reg(ssad_pkg::REG_BLINK_PERIOD, 16'($urandom_range(1, 60)));
				end
				5: begin
					write_reg(REG_UNMAPPED, 16'($urandom()));
					write_reg(ssad_pkg::REG_HOLD_PERIOD, 16'd2);
					write_reg(ssad_pkg::REG_BLINK_THRESHOLD, 16'd1);
					write_reg(ssad_pkg::REG_BLINK_PERIOD, 16'd3);
				end
				default: begin
					write_reg(ssad_pkg::REG_HOLD_PERIOD, 16'd10);
					write_reg(ssad_pkg::REG_BLINK_THRESHOLD, 16'd20);
					write_reg(ssad_pkg::REG_BLINK_PERIOD, 16'd41);
				end
			endcase
			for (int n = 0; n < TICKS_PER_PHASE; n++) begin
				// alert comes in runs so blinking can develop
				if (alert_left == 0) begin
					alert_now = ($urandom_range(0, 2) != 0);
					alert_left = $urandom_range(5, 120);
				end
				alert_left--;
				pending_readings.push_back(random_reading(alert_now));
				ticks_issued++;
			end
			// sink holds off while the sender keeps offering
			if (ph == 2 || ph == 5) long_stall_req++;
			wait_drained();
		end

		repeat (8) @(posedge clk);
		if (fail_count == 0 && expected_drive.size() == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule
